// ===== rtl/core/bejs_pkg.sv =====
// ----------------------------------------------------------------------------
// bejs_pkg: shared types and constants for the button edge / joystick scaler
// Beat layouts, register indexes, event codes, state codes and the widths of
// the shared serial divider.
// ----------------------------------------------------------------------------
package bejs_pkg;

    // Converter sample width and full-scale value
    localparam int RAW_W      = 10;
    localparam int SAMPLE_MAX = 1023;
    localparam logic [RAW_W-1:0] SAMPLE_MAX_RAW = RAW_W'(SAMPLE_MAX);

    localparam int BTN_W   = 6;
    localparam int POS_W   = 8;
    localparam int THR_W   = 8;
    localparam int DIV_W   = 8;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 2;

    // Divider: numerator is a sample times 128 (or 127), quotient stays below 256
    localparam int NUM_W  = RAW_W + 7;
    localparam int QUOT_W = POS_W;
    localparam int CNT_W  = $clog2(QUOT_W);

    // Reset values of registers and state
    localparam logic [RAW_W-1:0] CENTRE_RESET    = RAW_W'(512);
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(4);
    localparam logic [DIV_W-1:0] DIVIDER_RESET   = DIV_W'(4);
    localparam logic [POS_W-1:0] POS_MID         = POS_W'(128);
    localparam logic [POS_W-1:0] POS_FULL        = POS_W'(255);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTRE_X,
        CFG_CENTRE_Y,
        CFG_MOVE_THRESHOLD,
        CFG_POLL_DIVIDER
    } cfg_index_t;

    // Event codes
    typedef enum logic [1:0] {
        EV_PRESS,
        EV_RELEASE,
        EV_MOVE
    } ev_kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_WAIT,
        ST_CMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [BTN_W-1:0] button_pins;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       event_kind;
        logic [POS_W-1:0] value_a;
        logic [POS_W-1:0] value_b;
        logic             last_of_run;
    } out_beat_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [RAW_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== rtl/core/button_edge_joystick_scaler.sv =====
// ----------------------------------------------------------------------------
// button_edge_joystick_scaler: button edge events and scaled joystick moves
//
// Each input beat is one poll tick: six active-low button pins and raw X/Y
// samples. The tick yields up to three output beats in the order press,
// release, move; last_of_run marks the final beat of the tick. A tick with
// no event yields no beat.
//
// Channels: in_valid/in_ready and out_valid/out_ready; a beat moves when
// valid and ready are both high. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data) to be used while the block is idle.
//
// Flow: in_ready is high only while idle. An evaluating tick runs both axes
// through one shared serial divider, one axis after the other; an axis whose
// sample is at or above a full-scale centre saturates without dividing.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset loads the register defaults and clears the button and tick state;
// the reported position returns to mid-scale.
// ----------------------------------------------------------------------------
module button_edge_joystick_scaler
    import bejs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers
    logic [RAW_W-1:0] centre_x_reg;
    logic [RAW_W-1:0] centre_y_reg;
    logic [THR_W-1:0] threshold_reg;
    logic [DIV_W-1:0] divider_reg;

    // Sequencer and tick state
    state_t           state_reg,     state_next;
    logic             axis_reg,      axis_next;
    logic             below_reg,     below_next;
    logic [BTN_W-1:0] prev_btn_reg,  prev_btn_next;
    logic [BTN_W-1:0] btn_reg,       btn_next;
    logic [DIV_W-1:0] tick_reg,      tick_next;
    logic [POS_W-1:0] rep_x_reg,     rep_x_next;
    logic [POS_W-1:0] rep_y_reg,     rep_y_next;
    logic             pend_press_reg, pend_press_next;
    logic             pend_rel_reg,   pend_rel_next;
    logic             pend_move_reg,  pend_move_next;
    logic             out_valid_reg,  out_valid_next;

    // Payload
    logic [RAW_W-1:0] raw_x_reg,     raw_x_next;
    logic [RAW_W-1:0] raw_y_reg,     raw_y_next;
    logic [POS_W-1:0] scaled_x_reg,  scaled_x_next;
    logic [POS_W-1:0] scaled_y_reg,  scaled_y_next;
    out_beat_t        out_data_reg,  out_data_next;

    div_req_t         div_req;
    div_rsp_t         div_rsp;
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [RAW_W-1:0] div_den;

    // Combinational helpers
    logic [BTN_W-1:0] cur_btn;
    logic [DIV_W-1:0] tick_inc;
    logic             eval_tick;
    logic [RAW_W-1:0] raw_sel;
    logic [RAW_W-1:0] cen_sel;
    logic             below_axis;
    logic             sat_axis;
    logic [RAW_W-1:0] offset;
    logic [POS_W-1:0] mapped;
    logic [POS_W-1:0] scaled_new;
    logic [POS_W-1:0] diff_x;
    logic [POS_W-1:0] diff_y;
    logic             move_hit;
    logic             out_free;

    // Shared divider
    bejs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign div_req = '{start: div_start, num: div_num, den: div_den};

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg  <= CENTRE_RESET;
            centre_y_reg  <= CENTRE_RESET;
            threshold_reg <= THRESHOLD_RESET;
            divider_reg   <= DIVIDER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTRE_X:       centre_x_reg  <= cfg_data[RAW_W-1:0];
                CFG_CENTRE_Y:       centre_y_reg  <= cfg_data[RAW_W-1:0];
                CFG_MOVE_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                CFG_POLL_DIVIDER:   divider_reg   <= cfg_data[DIV_W-1:0];
                default:            ;
            endcase
        end
    end

    // Axis set-up: pick the mapping branch and build the divider operands
    always_comb
    begin
        raw_sel    = axis_reg ? raw_y_reg : raw_x_reg;
        cen_sel    = axis_reg ? centre_y_reg : centre_x_reg;
        below_axis = (raw_sel < cen_sel);
        sat_axis   = (cen_sel >= SAMPLE_MAX_RAW);
        offset     = raw_sel - cen_sel;

        div_num = below_axis ? {raw_sel, 7'b0}
                             : ({offset, 7'b0} - {7'b0, offset});
        div_den = below_axis ? cen_sel : (SAMPLE_MAX_RAW - cen_sel);

        // Upper half sits above mid-scale; quotient never exceeds 127 there
        mapped     = below_reg ? div_rsp.quot : (POS_MID + div_rsp.quot);
        scaled_new = POS_FULL - mapped;
    end

    // Move check against the reported position
    always_comb
    begin
        diff_x   = (scaled_x_reg > rep_x_reg) ? (scaled_x_reg - rep_x_reg)
                                              : (rep_x_reg - scaled_x_reg);
        diff_y   = (scaled_y_reg > rep_y_reg) ? (scaled_y_reg - rep_y_reg)
                                              : (rep_y_reg - scaled_y_reg);
        move_hit = (diff_x > threshold_reg) || (diff_y > threshold_reg);
    end

    // Sequencer: next state and outputs
    always_comb
    begin
        cur_btn   = ~in_data.button_pins;
        tick_inc  = tick_reg + 1'b1;
        eval_tick = (tick_inc >= divider_reg);
        out_free  = !out_valid_reg || out_ready;

        state_next      = state_reg;
        axis_next       = axis_reg;
        below_next      = below_reg;
        prev_btn_next   = prev_btn_reg;
        btn_next        = btn_reg;
        tick_next       = tick_reg;
        rep_x_next      = rep_x_reg;
        rep_y_next      = rep_y_reg;
        pend_press_next = pend_press_reg;
        pend_rel_next   = pend_rel_reg;
        pend_move_next  = pend_move_reg;
        raw_x_next      = raw_x_reg;
        raw_y_next      = raw_y_reg;
        scaled_x_next   = scaled_x_reg;
        scaled_y_next   = scaled_y_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        in_ready        = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    // Take the tick: button edges now, joystick if due
                    pend_press_next = |(cur_btn & ~prev_btn_reg);
                    pend_rel_next   = |(~cur_btn & prev_btn_reg);
                    pend_move_next  = 1'b0;
                    prev_btn_next   = cur_btn;
                    btn_next        = cur_btn;
                    raw_x_next      = in_data.raw_x;
                    raw_y_next      = in_data.raw_y;
                    axis_next       = 1'b0;
                    tick_next       = eval_tick ? '0 : tick_inc;
                    state_next      = eval_tick ? ST_MAP : ST_EMIT;
                end
            end

            ST_MAP:
            begin
                if (!below_axis && sat_axis)
                begin
                    // Centre at full scale: saturate without dividing
                    if (axis_reg)
                    begin
                        scaled_y_next = '0;
                        state_next    = ST_CMP;
                    end
                    else
                    begin
                        scaled_x_next = '0;
                        axis_next     = 1'b1;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    below_next = below_axis;
                    state_next = ST_WAIT;
                end
            end

            ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (axis_reg)
                    begin
                        scaled_y_next = scaled_new;
                        state_next    = ST_CMP;
                    end
                    else
                    begin
                        scaled_x_next = scaled_new;
                        axis_next     = 1'b1;
                        state_next    = ST_MAP;
                    end
                end
            end

            ST_CMP:
            begin
                pend_move_next = move_hit;
                if (move_hit)
                begin
                    rep_x_next = scaled_x_reg;
                    rep_y_next = scaled_y_reg;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!pend_press_reg && !pend_rel_reg && !pend_move_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    // Send the next pending event in the order press, release, move
                    out_valid_next = 1'b1;
                    if (pend_press_reg)
                    begin
                        out_data_next.event_kind  = EV_PRESS;
                        out_data_next.value_a     = POS_W'(btn_reg);
                        out_data_next.value_b     = '0;
                        out_data_next.last_of_run = !pend_rel_reg && !pend_move_reg;
                        pend_press_next           = 1'b0;
                    end
                    else if (pend_rel_reg)
                    begin
                        out_data_next.event_kind  = EV_RELEASE;
                        out_data_next.value_a     = POS_W'(btn_reg);
                        out_data_next.value_b     = '0;
                        out_data_next.last_of_run = !pend_move_reg;
                        pend_rel_next             = 1'b0;
                    end
                    else
                    begin
                        out_data_next.event_kind  = EV_MOVE;
                        out_data_next.value_a     = rep_x_reg;
                        out_data_next.value_b     = rep_y_reg;
                        out_data_next.last_of_run = 1'b1;
                        pend_move_next            = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axis_reg       <= 1'b0;
            below_reg      <= 1'b0;
            prev_btn_reg   <= '0;
            tick_reg       <= '0;
            rep_x_reg      <= POS_MID;
            rep_y_reg      <= POS_MID;
            pend_press_reg <= 1'b0;
            pend_rel_reg   <= 1'b0;
            pend_move_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            below_reg      <= below_next;
            prev_btn_reg   <= prev_btn_next;
            tick_reg       <= tick_next;
            rep_x_reg      <= rep_x_next;
            rep_y_reg      <= rep_y_next;
            pend_press_reg <= pend_press_next;
            pend_rel_reg   <= pend_rel_next;
            pend_move_reg  <= pend_move_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        btn_reg      <= btn_next;
        raw_x_reg    <= raw_x_next;
        raw_y_reg    <= raw_y_next;
        scaled_x_reg <= scaled_x_next;
        scaled_y_reg <= scaled_y_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Divider results only arrive while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_WAIT))
        else $error("divider result outside wait state");

    // Button events carry only the six-bit set and no Y value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.event_kind != EV_MOVE)) |->
            ((out_data.value_b == '0) && (out_data.value_a[POS_W-1:BTN_W] == '0)))
        else $error("button beat with stray payload bits");

    // A taken tick blocks the input until its work is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken twice in a row");

    // Hold a stalled output beat unchanged until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("output beat changed while stalled");

endmodule

// ===== rtl/core/bejs_div.sv =====
// ----------------------------------------------------------------------------
// bejs_div: serial restoring divider
// Produces one quotient bit per cycle. The caller guarantees the quotient
// fits QUOT_W bits, so the upper numerator bits preload the remainder and
// only QUOT_W steps run. done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module bejs_div
    import bejs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [RAW_W-1:0]  rem_reg,   rem_next;
    logic [QUOT_W-1:0] quo_reg,   quo_next;
    logic [RAW_W-1:0]  den_reg,   den_next;

    logic [RAW_W:0]    trial;
    logic [RAW_W:0]    diff;
    logic              fits;

    // One restoring step: shift in the next numerator bit, try the subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[QUOT_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = RAW_W'(req.num[NUM_W-1:QUOT_W]);
            quo_next  = req.num[QUOT_W-1:0];
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
            quo_next = {quo_reg[QUOT_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

// ===== tb/sv/bejs_event_checker.sv =====
// ----------------------------------------------------------------------------
// bejs_event_checker: event predictor and scoreboard for the scaler
// Watches the configuration port and both channels. For each poll tick beat
// taken at the input it predicts the press, release and move beats the tick
// must yield, and compares every output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module bejs_event_checker
    import bejs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_beat_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_beat_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   pending,
    output int                   presses,
    output int                   releases,
    output int                   moves
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow registers and tick state
    logic [RAW_W-1:0] centre_x_q;
    logic [RAW_W-1:0] centre_y_q;
    logic [THR_W-1:0] threshold_q;
    logic [DIV_W-1:0] divider_q;
    logic [BTN_W-1:0] held_q;
    logic [7:0]       tick_q;
    logic [POS_W-1:0] shown_x_q;
    logic [POS_W-1:0] shown_y_q;

    out_beat_t expected_events[$];

    // Map one raw sample around its centre to 0..255, then invert
    function automatic logic [POS_W-1:0] map_axis(logic [RAW_W-1:0] raw,
                                                  logic [RAW_W-1:0] centre);
        int r;
        int c;
        int v;
        r = raw;
        c = centre;
        if (r < c)
            v = (r * 128) / c;
        else if (c >= SAMPLE_MAX)
            v = 255;
        else
            v = 128 + ((r - c) * 127) / (SAMPLE_MAX - c);
        if (v > 255)
            v = 255;
        return POS_W'(255 - v);
    endfunction

    // Work out the beats of one poll tick and queue them in order
    task automatic predict_tick(input in_beat_t beat);
        out_beat_t        evs[3];
        int               n;
        int               dx;
        int               dy;
        logic [BTN_W-1:0] now_held;
        logic [POS_W-1:0] fx;
        logic [POS_W-1:0] fy;
        n = 0;
        now_held = ~beat.button_pins;
        if ((now_held & ~held_q) != '0)
        begin
            evs[n] = '{event_kind: EV_PRESS, value_a: POS_W'(now_held),
                       value_b: '0, last_of_run: 1'b0};
            n++;
        end
        if ((~now_held & held_q) != '0)
        begin
            evs[n] = '{event_kind: EV_RELEASE, value_a: POS_W'(now_held),
                       value_b: '0, last_of_run: 1'b0};
            n++;
        end
        held_q = now_held;

        // Evaluate the stick on every divider-th tick
        tick_q = tick_q + 8'd1;
        if (tick_q >= divider_q)
        begin
            tick_q = '0;
            fx = map_axis(beat.raw_x, centre_x_q);
            fy = map_axis(beat.raw_y, centre_y_q);
            dx = int'(fx) - int'(shown_x_q);
            dy = int'(fy) - int'(shown_y_q);
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            if (dx > int'(threshold_q) || dy > int'(threshold_q))
            begin
                evs[n] = '{event_kind: EV_MOVE, value_a: fx, value_b: fy,
                           last_of_run: 1'b0};
                n++;
                shown_x_q = fx;
                shown_y_q = fy;
            end
        end

        if (n > 0)
            evs[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_events.push_back(evs[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_beat_t want;
        if (!rst_n)
        begin
            centre_x_q  = CENTRE_RESET;
            centre_y_q  = CENTRE_RESET;
            threshold_q = THRESHOLD_RESET;
            divider_q   = DIVIDER_RESET;
            held_q      = '0;
            tick_q      = '0;
            shown_x_q   = POS_MID;
            shown_y_q   = POS_MID;
            expected_events.delete();
            mismatches  = 0;
            presses     = 0;
            releases    = 0;
            moves       = 0;
            pending    <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_CENTRE_X:       centre_x_q  = cfg_data[RAW_W-1:0];
                    CFG_CENTRE_Y:       centre_y_q  = cfg_data[RAW_W-1:0];
                    CFG_MOVE_THRESHOLD: threshold_q = cfg_data[THR_W-1:0];
                    CFG_POLL_DIVIDER:   divider_q   = cfg_data[DIV_W-1:0];
                    default: ;
                endcase
            end

            // Match each output beat against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected beat kind=%0d a=%0d b=%0d last=%0d",
                             $time, out_data.event_kind, out_data.value_a,
                             out_data.value_b, out_data.last_of_run);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (out_data !== want)
                    begin
                        $display("%0t: expected kind=%0d a=%0d b=%0d last=%0d, got kind=%0d a=%0d b=%0d last=%0d",
                                 $time, want.event_kind, want.value_a, want.value_b,
                                 want.last_of_run, out_data.event_kind, out_data.value_a,
                                 out_data.value_b, out_data.last_of_run);
                        mismatches++;
                    end
                end
                case (ev_kind_t'(out_data.event_kind))
                    EV_PRESS:   presses++;
                    EV_RELEASE: releases++;
                    EV_MOVE:    moves++;
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                predict_tick(in_data);

            pending <= expected_events.size();
        end
    end

endmodule

// ===== tb/sv/tb_button_edge_joystick_scaler.sv =====
// ----------------------------------------------------------------------------
// tb_button_edge_joystick_scaler: stimulus and verdict for the scaler
// Drives poll ticks through a directed opening and random phases under
// several register settings, with random idle cycles on both channels, one
// long receiver hold and drained pauses before each register update.
// ----------------------------------------------------------------------------
module tb_button_edge_joystick_scaler
    import bejs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int STUCK_LIMIT   = 3000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_beat_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_beat_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int pending;
    int presses;
    int releases;
    int moves;

    int               ticks_sent;
    int               settings_loaded;
    int               stuck_cycles;
    bit               tx_burst;
    bit               rx_burst;
    bit               squeeze_req;
    bit               squeeze_done;
    logic [BTN_W-1:0] last_pins;
    logic [RAW_W-1:0] last_x;
    logic [RAW_W-1:0] last_y;
    logic [RAW_W-1:0] cur_cx;
    logic [RAW_W-1:0] cur_cy;

    button_edge_joystick_scaler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bejs_event_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .presses    (presses),
        .releases   (releases),
        .moves      (moves)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STUCK_LIMIT);
            $display("tb_button_edge_joystick_scaler: done, errors");
            $finish;
        end
    end

    // Receiver: random gap before each beat, one long hold when asked
    initial
    begin : rx
        int gap;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (squeeze_req && !squeeze_done)
            begin
                gap = LONG_HOLD;
                squeeze_done = 1'b1;
            end
            else
                gap = rx_burst ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 24) == 0)
                rx_burst = !rx_burst;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one tick beat after a random gap and hold it until taken
    task automatic offer_tick(input in_beat_t beat);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 24) == 0)
            tx_burst = !tx_burst;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= beat;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        last_pins = beat.button_pins;
        last_x    = beat.raw_x;
        last_y    = beat.raw_y;
        ticks_sent++;
    endtask

    task automatic send_fields(input logic [BTN_W-1:0] pins, input int x, input int y);
        in_beat_t beat;
        beat.button_pins = pins;
        beat.raw_x       = RAW_W'(x);
        beat.raw_y       = RAW_W'(y);
        offer_tick(beat);
    endtask

    // Drop valid and wait until the block has drained and gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                                 input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] dv);
        settle();
        write_reg(CFG_CENTRE_X, cx);
        write_reg(CFG_CENTRE_Y, cy);
        write_reg(CFG_MOVE_THRESHOLD, thr);
        write_reg(CFG_POLL_DIVIDER, dv);
        cfg_we <= 1'b0;
        cur_cx = cx;
        cur_cy = cy;
        settings_loaded++;
    endtask

    // Mostly small moves around the last sample, with jumps and extremes
    function automatic logic [RAW_W-1:0] pick_raw(logic [RAW_W-1:0] last,
                                                  logic [RAW_W-1:0] centre);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'(last) + int'($urandom_range(0, 40)) - 20;
            4, 5, 6:    v = $urandom_range(0, SAMPLE_MAX);
            7:          v = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : 0;
            default:    v = int'(centre) + int'($urandom_range(0, 6)) - 3;
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return RAW_W'(v);
    endfunction

    task automatic run_random(input int count, input bit squeeze);
        in_beat_t beat;
        for (int i = 0; i < count; i++)
        begin
            if (squeeze && i == count / 8)
                squeeze_req = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    beat.button_pins = last_pins ^ (BTN_W'(1) << $urandom_range(0, BTN_W-1));
                6:       beat.button_pins = last_pins ^ BTN_W'($urandom);
                7:       beat.button_pins = '1;
                8:       beat.button_pins = '0;
                default: beat.button_pins = last_pins;
            endcase
            beat.raw_x = pick_raw(last_x, cur_cx);
            beat.raw_y = pick_raw(last_y, cur_cy);
            offer_tick(beat);
        end
    endtask

    initial
    begin : stim
        logic [CFG_W-1:0] thr;
        logic [CFG_W-1:0] dv;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_CENTRE_X;
        cfg_data  <= '0;
        last_pins = '1;
        last_x    = RAW_W'(512);
        last_y    = RAW_W'(512);
        cur_cx    = CENTRE_RESET;
        cur_cy    = CENTRE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: all pressed, all released, single edges, swaps
        send_fields(6'h3F, 512, 512);
        send_fields(6'h00, 0, 0);
        send_fields(6'h3F, 1023, 1023);
        send_fields(6'h3E, 511, 513);
        send_fields(6'h3D, 0, 1023);
        send_fields(6'h1F, 1023, 0);
        send_fields(6'h2F, 600, 400);
        send_fields(6'h3F, 512, 512);

        // Centre zero on X, centre at full scale on Y, zero threshold
        load_settings(10'd0, 10'd1023, 10'd0, 10'd1);
        send_fields(6'h3F, 0, 0);
        send_fields(6'h3E, 1023, 1023);
        send_fields(6'h3D, 1023, 1023);
        send_fields(6'h2A, 0, 1022);
        send_fields(6'h15, 511, 1023);
        send_fields(6'h3F, 1, 1022);
        send_fields(6'h00, 1023, 0);
        send_fields(6'h3F, 1023, 0);

        // Divider zero evaluates every tick
        load_settings(10'd1023, 10'd0, 10'd0, 10'd0);
        send_fields(6'h3F, 1023, 0);
        send_fields(6'h3F, 1022, 1023);
        send_fields(6'h00, 0, 512);
        send_fields(6'h3F, 1023, 1023);
        send_fields(6'h3F, 1023, 1023);

        // Random phases, the first one with a long receiver hold
        load_settings(10'd512, 10'd512, 10'd4, 10'd1);
        run_random(80, 1'b1);
        load_settings(10'd1022, 10'd1, 10'h3FF, 10'h3FF);
        run_random(20, 1'b0);
        for (int k = 0; k < 5; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                thr = CFG_W'($urandom_range(0, 255));
            else
                thr = CFG_W'($urandom_range(0, 24));
            if ($urandom_range(0, 7) == 0)
                dv = '0;
            else
                dv = CFG_W'($urandom_range(1, 6));
            load_settings(CFG_W'($urandom_range(0, SAMPLE_MAX)),
                          CFG_W'($urandom_range(0, SAMPLE_MAX)),
                          thr | CFG_W'($urandom_range(0, 3) << 8),
                          dv | CFG_W'($urandom_range(0, 3) << 8));
            run_random(64, 1'b0);
        end

        // Drain and give late beats a chance to show up
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d poll ticks under %0d register settings plus reset defaults.",
                 ticks_sent, settings_loaded);
        $display("Beats checked: %0d press, %0d release, %0d move.", presses, releases, moves);
        if (mismatches == 0 && pending == 0)
            $display("tb_button_edge_joystick_scaler: done, clean");
        else
            $display("tb_button_edge_joystick_scaler: done, errors");
        $finish;
    end

endmodule
